// ===== rtl/core/bcqg_pkg.sv =====
// Shared types and constants for the peak cluster labeler.
package bcqg_pkg;

    localparam int MASS_W  = 32;
    localparam int INTEN_W = 32;
    localparam int LABEL_W = 32;
    localparam int COEF_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam int MUL_W  = COEF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * MASS_W;
    localparam int ACC_W  = 100;
    localparam int DIFF_W = 35;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUADRATIC = 2'd2;

    localparam logic signed [COEF_W-1:0] INTERCEPT_RESET = 32'sd72090;
    localparam logic signed [COEF_W-1:0] LINEAR_RESET    = 32'sd0;
    localparam logic signed [COEF_W-1:0] QUADRATIC_RESET = 32'sd0;

    typedef struct packed {
        logic [MASS_W-1:0]  point_mass;
        logic [INTEN_W-1:0] point_intensity;
        logic               first_point;
    } point_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] gap_intercept;
        logic signed [COEF_W-1:0] gap_linear;
        logic signed [COEF_W-1:0] gap_quadratic;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LIN  = 6'b000010,
        ST_QLO  = 6'b000100,
        ST_QHI  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_DONE = 6'b100000
    } back_state_t;

endpackage

// ===== rtl/core/bcqg_point_if.sv =====
// Input channel carrying one spectrum point per transfer.
interface bcqg_point_if;
    logic                            valid;
    logic                            ready;
    logic [bcqg_pkg::MASS_W-1:0]     point_mass;
    logic [bcqg_pkg::INTEN_W-1:0]    point_intensity;
    logic                            first_point;

    modport source (output valid, output point_mass, output point_intensity,
                    output first_point, input ready);
    modport sink   (input valid, input point_mass, input point_intensity,
                    input first_point, output ready);
endinterface

// ===== rtl/core/bcqg_label_if.sv =====
// Output channel carrying one cluster label per transfer.
interface bcqg_label_if;
    logic                          valid;
    logic                          ready;
    logic [bcqg_pkg::LABEL_W-1:0]  cluster_label;

    modport source (output valid, output cluster_label, input ready);
    modport sink   (input valid, input cluster_label, output ready);
endinterface

// ===== rtl/core/bcqg_front.sv =====
// Front end: accepts points and holds them in a two-entry queue for the back end.
module bcqg_front (
    input  logic                clk,
    input  logic                rst_n,
    bcqg_point_if.sink          point,
    output bcqg_pkg::point_t    head,
    output logic                head_valid,
    input  logic                head_pop
);

    bcqg_pkg::point_t                   data_reg [bcqg_pkg::QUEUE_DEPTH];
    logic [bcqg_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bcqg_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bcqg_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               push;
    logic                               pop;
    bcqg_pkg::point_t                   in_item;

    assign point.ready = (count_reg != bcqg_pkg::QCNT_W'(bcqg_pkg::QUEUE_DEPTH));
    assign push        = point.valid && point.ready;
    assign head_valid  = (count_reg != '0);
    assign pop         = head_pop && head_valid;
    assign head        = data_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.point_mass      = point.point_mass;
        in_item.point_intensity = point.point_intensity;
        in_item.first_point     = point.first_point;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/bcqg_back.sv =====
// Back end: gap threshold sequencer on a shared multiplier, label update, output register.
module bcqg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bcqg_pkg::cfg_t      cfg,
    input  bcqg_pkg::point_t    head,
    input  logic                head_valid,
    output logic                head_pop,
    bcqg_label_if.source        label
);

    bcqg_pkg::back_state_t              state_reg, state_next;

    logic [bcqg_pkg::MASS_W-1:0]        last_mass_reg, last_mass_next;
    logic [bcqg_pkg::INTEN_W-1:0]       last_inten_reg, last_inten_next;
    logic                               was_rising_reg, was_rising_next;
    logic [bcqg_pkg::LABEL_W-1:0]       count_reg, count_next;

    logic [bcqg_pkg::MASS_W-1:0]        cur_mass_reg, cur_mass_next;
    logic [bcqg_pkg::INTEN_W-1:0]       cur_inten_reg, cur_inten_next;
    logic                               cur_first_reg, cur_first_next;

    logic signed [bcqg_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bcqg_pkg::SQ_W-1:0]          sq_reg, sq_next;
    logic [bcqg_pkg::ACC_W-1:0]         acc_reg, acc_next;

    logic                               out_valid_reg, out_valid_next;
    logic [bcqg_pkg::LABEL_W-1:0]       out_label_reg, out_label_next;

    logic signed [bcqg_pkg::MUL_W-1:0]  mul_a;
    logic signed [bcqg_pkg::MUL_W-1:0]  mul_b;
    logic signed [bcqg_pkg::PROD_W-1:0] mul_p;
    logic [bcqg_pkg::DIFF_W-1:0]        diff;
    logic [bcqg_pkg::ACC_W-1:0]         prod_wide;
    logic [bcqg_pkg::ACC_W-1:0]         prod_wide_hi;
    logic                               out_free;
    logic                               exceeds;
    logic                               rising;
    logic                               bump;

    assign label.valid         = out_valid_reg;
    assign label.cluster_label = out_label_reg;
    assign out_free            = !out_valid_reg || label.ready;
    assign head_pop            = (state_reg == bcqg_pkg::ST_IDLE) && head_valid;

    // (gap - c0) in 35-bit two's complement
    assign diff = {3'b000, head.point_mass} - {3'b000, last_mass_reg}
                - {{3{cfg.gap_intercept[bcqg_pkg::COEF_W-1]}}, cfg.gap_intercept};

    assign prod_wide    = {{(bcqg_pkg::ACC_W-bcqg_pkg::PROD_W){prod_reg[bcqg_pkg::PROD_W-1]}},
                           prod_reg};
    assign prod_wide_hi = {{2{prod_reg[bcqg_pkg::PROD_W-1]}}, prod_reg, 32'd0};

    assign mul_p   = mul_a * mul_b;
    assign exceeds = !acc_reg[bcqg_pkg::ACC_W-1] && (acc_reg != '0);
    assign rising  = cur_inten_reg > last_inten_reg;
    assign bump    = exceeds || (!was_rising_reg && rising);

    always_comb
    begin
        case (state_reg)
            bcqg_pkg::ST_LIN:
            begin
                mul_a = {cfg.gap_linear[bcqg_pkg::COEF_W-1], cfg.gap_linear};
                mul_b = {1'b0, last_mass_reg};
            end
            bcqg_pkg::ST_QLO:
            begin
                mul_a = {cfg.gap_quadratic[bcqg_pkg::COEF_W-1], cfg.gap_quadratic};
                mul_b = {1'b0, sq_reg[31:0]};
            end
            bcqg_pkg::ST_QHI:
            begin
                mul_a = {cfg.gap_quadratic[bcqg_pkg::COEF_W-1], cfg.gap_quadratic};
                mul_b = {1'b0, sq_reg[63:32]};
            end
            default:
            begin
                mul_a = {1'b0, last_mass_reg};
                mul_b = {1'b0, last_mass_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        last_mass_next  = last_mass_reg;
        last_inten_next = last_inten_reg;
        was_rising_next = was_rising_reg;
        count_next      = count_reg;
        cur_mass_next   = cur_mass_reg;
        cur_inten_next  = cur_inten_reg;
        cur_first_next  = cur_first_reg;
        prod_next       = prod_reg;
        sq_next         = sq_reg;
        acc_next        = acc_reg;
        out_label_next  = out_label_reg;
        out_valid_next  = out_valid_reg;

        if (label.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bcqg_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    cur_mass_next  = head.point_mass;
                    cur_inten_next = head.point_intensity;
                    cur_first_next = head.first_point;
                    prod_next      = mul_p;
                    acc_next       = {diff[bcqg_pkg::DIFF_W-1], diff, 64'd0};
                    state_next     = head.first_point ? bcqg_pkg::ST_DONE
                                                      : bcqg_pkg::ST_LIN;
                end
            end
            bcqg_pkg::ST_LIN:
            begin
                sq_next    = prod_reg[bcqg_pkg::SQ_W-1:0];
                prod_next  = mul_p;
                state_next = bcqg_pkg::ST_QLO;
            end
            bcqg_pkg::ST_QLO:
            begin
                acc_next   = acc_reg - prod_wide_hi;
                prod_next  = mul_p;
                state_next = bcqg_pkg::ST_QHI;
            end
            bcqg_pkg::ST_QHI:
            begin
                acc_next   = acc_reg - prod_wide;
                prod_next  = mul_p;
                state_next = bcqg_pkg::ST_ACC;
            end
            bcqg_pkg::ST_ACC:
            begin
                acc_next   = acc_reg - prod_wide_hi;
                state_next = bcqg_pkg::ST_DONE;
            end
            bcqg_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    if (cur_first_reg)
                    begin
                        count_next      = '0;
                        was_rising_next = 1'b1;
                    end
                    else
                    begin
                        if (bump && (count_reg != '1))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        was_rising_next = rising;
                    end
                    last_mass_next  = cur_mass_reg;
                    last_inten_next = cur_inten_reg;
                    out_label_next  = count_next;
                    out_valid_next  = 1'b1;
                    state_next      = bcqg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcqg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bcqg_pkg::ST_IDLE;
            last_mass_reg  <= '0;
            last_inten_reg <= '0;
            was_rising_reg <= 1'b1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_mass_reg  <= last_mass_next;
            last_inten_reg <= last_inten_next;
            was_rising_reg <= was_rising_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mass_reg  <= cur_mass_next;
        cur_inten_reg <= cur_inten_next;
        cur_first_reg <= cur_first_next;
        prod_reg      <= prod_next;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        out_label_reg <= out_label_next;
    end

endmodule

// ===== rtl/core/bitonic_cluster_quadratic_gap.sv =====
// Top level of the peak cluster labeler: config registers, front queue, back sequencer.
// Flow: a first point goes from the queue head straight to the done state; any other point
// first runs the back end's linear, quadratic low, quadratic high and accumulate steps.
// The back end takes a new point only when idle, while the queue holds up to two more; the four products
// share the single 33x33 multiplier. Results wait in an output register while work goes on.
// Reset: threshold registers to 72090/0/0, queue empty, previous point mass 0, intensity 0,
// direction rising, label count 0.
module bitonic_cluster_quadratic_gap (
    input  logic                            clk,
    input  logic                            rst_n,
    bcqg_point_if.sink                      point,
    bcqg_label_if.source                    label,
    input  logic                            cfg_we,
    input  logic [bcqg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcqg_pkg::COEF_W-1:0]     cfg_data
);

    bcqg_pkg::cfg_t     cfg_reg, cfg_next;
    bcqg_pkg::point_t   head;
    logic               head_valid;
    logic               head_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bcqg_pkg::CFG_INTERCEPT: cfg_next.gap_intercept = cfg_data;
                bcqg_pkg::CFG_LINEAR:    cfg_next.gap_linear    = cfg_data;
                bcqg_pkg::CFG_QUADRATIC: cfg_next.gap_quadratic = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_intercept <= bcqg_pkg::INTERCEPT_RESET;
            cfg_reg.gap_linear    <= bcqg_pkg::LINEAR_RESET;
            cfg_reg.gap_quadratic <= bcqg_pkg::QUADRATIC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcqg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    bcqg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .label      (label)
    );

endmodule
